// ===== rtl/core/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master - shared definitions
// Action codes, segment encodings and the per-command segment programs.
// ----------------------------------------------------------------------------
package i2cee_pkg;

   // Action carried on the input tuser
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_PROBE = 2'd3
   } act_type;

   // Segment kinds of a command program
   typedef enum logic [2:0] {
      SK_START   = 3'd0,
      SK_STOP    = 3'd1,
      SK_PUT     = 3'd2,
      SK_GET     = 3'd3,
      SK_END     = 3'd4,
      SK_POLLEND = 3'd5
   } seg_kind_type;

   // Byte source of a put segment
   typedef enum logic [2:0] {
      SRC_NONE  = 3'd0,
      SRC_ADDRW = 3'd1,
      SRC_ADDRR = 3'd2,
      SRC_HI    = 3'd3,
      SRC_LO    = 3'd4,
      SRC_DATA  = 3'd5
   } src_type;

   // What to do with the ack of a put segment
   typedef enum logic [1:0] {
      CHK_IGNORE = 2'd0,
      CHK_ABORT  = 2'd1,
      CHK_PROBE  = 2'd2,
      CHK_POLL   = 2'd3
   } chk_type;

   typedef struct packed {
      seg_kind_type kind;
      src_type      src;
      chk_type      chk;
   } seg_type;

   localparam int unsigned ProgLen = 12;
   localparam int unsigned StageW  = 4;

   // Write-poll loop restarts at this segment
   localparam logic [StageW-1:0] POLL_LOOP_STAGE = 4'd6;

   // Put phases: eight bits of three steps, then the ack clock
   localparam logic [4:0] PUT_ACK_SDA  = 5'd24;
   localparam logic [4:0] PUT_ACK_HIGH = 5'd25;
   localparam logic [4:0] PUT_ACK_LOW  = 5'd26;
   // Get phases: two setup steps, eight bits of two steps, then the no-ack clock
   localparam logic [4:0] GET_BITS_END = 5'd18;
   localparam logic [4:0] GET_NAK_HIGH = 5'd19;
   localparam logic [4:0] GET_NAK_LOW  = 5'd20;

   localparam seg_type SEG_START  = '{SK_START, SRC_NONE,  CHK_IGNORE};
   localparam seg_type SEG_STOP   = '{SK_STOP,  SRC_NONE,  CHK_IGNORE};
   localparam seg_type SEG_END    = '{SK_END,   SRC_NONE,  CHK_IGNORE};
   localparam seg_type SEG_GET    = '{SK_GET,   SRC_NONE,  CHK_IGNORE};
   localparam seg_type SEG_ADDR_A = '{SK_PUT,   SRC_ADDRW, CHK_ABORT};
   localparam seg_type SEG_ADDR_P = '{SK_PUT,   SRC_ADDRW, CHK_PROBE};
   localparam seg_type SEG_ADDR_L = '{SK_PUT,   SRC_ADDRW, CHK_POLL};
   localparam seg_type SEG_ADDR_R = '{SK_PUT,   SRC_ADDRR, CHK_IGNORE};
   localparam seg_type SEG_HI     = '{SK_PUT,   SRC_HI,    CHK_IGNORE};
   localparam seg_type SEG_LO     = '{SK_PUT,   SRC_LO,    CHK_IGNORE};
   localparam seg_type SEG_DATA   = '{SK_PUT,   SRC_DATA,  CHK_IGNORE};
   localparam seg_type SEG_POLL   = '{SK_POLLEND, SRC_NONE, CHK_IGNORE};

   // Segment program lookup: command kind and segment index
   function automatic seg_type prog_seg(input act_type kind,
                                        input logic [StageW-1:0] stage);
      seg_type s;
      s = SEG_END;
      case (kind)
         ACT_READ: begin
            case (stage)
               4'd0:    s = SEG_START;
               4'd1:    s = SEG_ADDR_A;
               4'd2:    s = SEG_HI;
               4'd3:    s = SEG_LO;
               4'd4:    s = SEG_STOP;
               4'd5:    s = SEG_START;
               4'd6:    s = SEG_ADDR_R;
               4'd7:    s = SEG_GET;
               4'd8:    s = SEG_STOP;
               default: s = SEG_END;
            endcase
         end
         ACT_WRITE: begin
            case (stage)
               4'd0:    s = SEG_START;
               4'd1:    s = SEG_ADDR_A;
               4'd2:    s = SEG_HI;
               4'd3:    s = SEG_LO;
               4'd4:    s = SEG_DATA;
               4'd5:    s = SEG_STOP;
               4'd6:    s = SEG_START;
               4'd7:    s = SEG_ADDR_L;
               4'd8:    s = SEG_STOP;
               4'd9:    s = SEG_POLL;
               default: s = SEG_END;
            endcase
         end
         ACT_PROBE: begin
            case (stage)
               4'd0:    s = SEG_START;
               4'd1:    s = SEG_ADDR_P;
               4'd2:    s = SEG_STOP;
               default: s = SEG_END;
            endcase
         end
         default: s = SEG_END;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/i2c_eeprom_byte_access_master_unit.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master
// Steps SCL/SDA one line change per tick beat through random read, byte write
// and address probe sequences; one result beat per input beat.
// ----------------------------------------------------------------------------
// The result beat is registered, loaded from the step logic on acceptance.
// Throughput: 1 beat per cycle while the consumer takes results; one line step is
//   one pass of the sequencer logic between the state registers and the result register.
// A waiting result does not block input while the consumer takes it this cycle.
// Reset (synchronous, active high): idle, SCL and SDA released, no result beat.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_unit
   import i2cee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input beat: command or tick
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic [31:0] req_tdata,   // [6:0] device_address, [22:7] byte_offset,
                                    // [30:23] write_data, [31] sda_in
   // Result beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] scl_level, [1] sda_level, [2] busy_res,
                                    // [3] done_res, [11:4] read_byte,
                                    // [12] nack_error, [15:13] zero
);

   // Handshake
   logic req_accept;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;

   // Input fields
   act_type     in_action;
   logic [6:0]  in_address;
   logic [15:0] in_offset;
   logic [7:0]  in_data;
   logic        in_sda;

   // Sequencer state
   logic              busy_ff, busy_in;
   logic              abort_ff, abort_in;
   logic              poll_nack_ff, poll_nack_in;
   logic [StageW-1:0] stage_ff, stage_in;
   logic [4:0]        phase_ff, phase_in;
   logic [3:0]        bit_cnt_ff, bit_cnt_in;
   logic [7:0]        shift_ff, shift_in;
   act_type           kind_ff, kind_in;
   logic [6:0]        addr_ff, addr_in;
   logic [15:0]       offset_ff, offset_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        rx_ff, rx_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in_nxt;
   logic              err_ff, err_in;

   // Step logic
   seg_type           seg_cur, seg_next;
   seg_kind_type      step_kind;
   logic              seg_end;
   logic              done;
   logic [7:0]        src_byte;
   logic [7:0]        shift_cur;
   logic [4:0]        put_sub;
   logic [StageW-1:0] stage_inc;

   assign in_action  = act_type'(req_tuser);
   assign in_address = req_tdata[6:0];
   assign in_offset  = req_tdata[22:7];
   assign in_data    = req_tdata[30:23];
   assign in_sda     = req_tdata[31];

   // Take a new beat whenever the result register is empty or being drained
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign seg_cur   = prog_seg(kind_ff, stage_ff);
   // An address nack turns the remaining steps into a stop
   assign step_kind = abort_ff ? SK_STOP : seg_cur.kind;
   assign stage_inc = (stage_ff == StageW'(ProgLen - 1)) ? '0 : stage_ff + 1'b1;
   assign seg_next  = prog_seg(kind_ff, stage_inc);

   // Byte to shift out for the current put segment
   always_comb begin
      case (seg_cur.src)
         SRC_ADDRW: src_byte = {addr_ff, 1'b0};
         SRC_ADDRR: src_byte = {addr_ff, 1'b1};
         SRC_HI:    src_byte = offset_ff[15:8];
         SRC_LO:    src_byte = offset_ff[7:0];
         SRC_DATA:  src_byte = data_ff;
         default:   src_byte = '0;
      endcase
   end

   // Step within a bit of a put: phase minus three per finished bit
   assign put_sub = (phase_ff == '0) ? '0
                  : phase_ff - {bit_cnt_ff, 1'b0} - {1'b0, bit_cnt_ff};

   always_comb begin
      busy_in      = busy_ff;
      abort_in     = abort_ff;
      poll_nack_in = poll_nack_ff;
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      bit_cnt_in   = bit_cnt_ff;
      shift_in     = shift_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      offset_in    = offset_ff;
      data_in      = data_ff;
      rx_in        = rx_ff;
      scl_in       = scl_ff;
      sda_in_nxt   = sda_ff;
      err_in       = err_ff;
      seg_end      = 1'b0;
      done         = 1'b0;
      shift_cur    = shift_ff;

      if (req_accept && in_action != ACT_TICK) begin
         // Latch a command only while idle; drop it otherwise
         if (!busy_ff) begin
            kind_in      = in_action;
            addr_in      = in_address;
            offset_in    = in_offset;
            data_in      = in_data;
            err_in       = 1'b0;
            abort_in     = 1'b0;
            poll_nack_in = 1'b0;
            stage_in     = '0;
            phase_in     = '0;
            bit_cnt_in   = '0;
            busy_in      = 1'b1;
         end
      end else if (req_accept && busy_ff) begin
         // One line step
         case (step_kind)
            SK_START: begin
               if (phase_ff == '0) begin
                  sda_in_nxt = 1'b0;
               end else begin
                  scl_in  = 1'b0;
                  seg_end = 1'b1;
               end
            end
            SK_STOP: begin
               if (phase_ff == 5'd0) begin
                  sda_in_nxt = 1'b0;
               end else if (phase_ff == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in_nxt = 1'b1;
                  seg_end    = 1'b1;
               end
            end
            SK_PUT: begin
               if (phase_ff == '0) begin
                  shift_cur  = src_byte;
                  shift_in   = src_byte;
                  bit_cnt_in = '0;
               end
               if (phase_ff < PUT_ACK_SDA) begin
                  if (put_sub == 5'd0) begin
                     sda_in_nxt = shift_cur[7];
                  end else if (put_sub == 5'd1) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in     = 1'b0;
                     shift_in   = {shift_cur[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_ff + 1'b1;
                  end
               end else if (phase_ff == PUT_ACK_SDA) begin
                  sda_in_nxt = 1'b1;
               end else if (phase_ff == PUT_ACK_HIGH) begin
                  scl_in = 1'b1;
               end else if (phase_ff == PUT_ACK_LOW) begin
                  // Sample the ack after the SCL-high step
                  scl_in = 1'b0;
                  if (seg_cur.chk == CHK_ABORT || seg_cur.chk == CHK_PROBE) begin
                     err_in = in_sda;
                  end else if (seg_cur.chk == CHK_POLL) begin
                     poll_nack_in = in_sda;
                  end
               end else begin
                  sda_in_nxt = 1'b0;
                  seg_end    = 1'b1;
                  if (seg_cur.chk == CHK_ABORT && err_ff) begin
                     abort_in = 1'b1;
                  end
               end
            end
            SK_GET: begin
               if (phase_ff == 5'd0) begin
                  scl_in     = 1'b0;
                  bit_cnt_in = '0;
                  shift_in   = '0;
               end else if (phase_ff == 5'd1) begin
                  sda_in_nxt = 1'b1;
               end else if (phase_ff < GET_BITS_END) begin
                  if (!phase_ff[0]) begin
                     scl_in = 1'b1;
                  end else begin
                     scl_in     = 1'b0;
                     shift_in   = {shift_ff[6:0], in_sda};
                     bit_cnt_in = bit_cnt_ff + 1'b1;
                  end
               end else if (phase_ff == GET_BITS_END) begin
                  sda_in_nxt = 1'b1;
               end else if (phase_ff == GET_NAK_HIGH) begin
                  scl_in = 1'b1;
               end else if (phase_ff == GET_NAK_LOW) begin
                  scl_in = 1'b0;
               end else begin
                  sda_in_nxt = 1'b0;
                  rx_in      = shift_ff;
                  seg_end    = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (seg_end) begin
            phase_in = '0;
            if (abort_ff) begin
               done = 1'b1;
            end else if (!abort_in) begin
               // Advance to the next segment; resolve poll loop and end marks
               stage_in = stage_inc;
               if (seg_next.kind == SK_POLLEND) begin
                  if (poll_nack_ff) begin
                     stage_in = POLL_LOOP_STAGE;
                  end else begin
                     done = 1'b1;
                  end
               end else if (seg_next.kind == SK_END) begin
                  done = 1'b1;
               end
            end
            if (done) begin
               busy_in  = 1'b0;
               abort_in = 1'b0;
               stage_in = '0;
            end
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   // Result beat register: load on accept, hold while stalled
   assign rsp_tvalid_in = req_accept || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = req_accept
                        ? {3'b000, err_in, rx_in, done, busy_in, sda_in_nxt, scl_in}
                        : rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         abort_ff      <= 1'b0;
         poll_nack_ff  <= 1'b0;
         stage_ff      <= '0;
         phase_ff      <= '0;
         bit_cnt_ff    <= '0;
         kind_ff       <= ACT_TICK;
         rx_ff         <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         err_ff        <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         busy_ff       <= busy_in;
         abort_ff      <= abort_in;
         poll_nack_ff  <= poll_nack_in;
         stage_ff      <= stage_in;
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         kind_ff       <= kind_in;
         rx_ff         <= rx_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_nxt;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      shift_ff     <= shift_in;
      addr_ff      <= addr_in;
      offset_ff    <= offset_in;
      data_ff      <= data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // A completing step never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_tdata_ff[3] && rsp_tdata_ff[2]))
      else $error("done and busy reported together");

   // Idle sequencer holds no leftover step or abort
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (phase_ff == '0 && !abort_ff && stage_ff == '0))
      else $error("idle with sequencer state left over");

   // Segment index stays within the program
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= StageW'(ProgLen - 1))
      else $error("segment index out of range");

   // A command taken while idle starts a sequence
   a_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && in_action != ACT_TICK && !busy_ff) |=> busy_ff)
      else $error("command accepted while idle did not start");

   // Phase never runs past the longest segment
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= 5'd27)
      else $error("step phase out of range");
`endif

endmodule
